### design/miller_rabin_primality_test_macros.svh
// assertion macros for the miller-rabin primality test block
// no dependencies; included by miller_rabin_primality_test, which carries the assertions
`ifndef MILLER_RABIN_PRIMALITY_TEST_MACROS_SVH
`define MILLER_RABIN_PRIMALITY_TEST_MACROS_SVH
`ifndef ASSERT_OFF
`define MR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mr assertion failed");
`define MR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("mr assertion failed");
`else
`define MR_ASSERT(lbl, clk, rstn, prop)
`define MR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### design/mr_pkg.sv
// shared types for the miller-rabin primality test block
// no dependencies; used by mr_modmul and miller_rabin_primality_test
package mr_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

### design/mr_modmul.sv
// bit-serial double-and-add modular multiplier, one multiplier bit per cycle
// depends on mr_pkg
module mr_modmul #(
    parameter int NUM_BITS = 63
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_BITS-1:0]   x,
    input  logic [NUM_BITS-1:0]   y,
    input  logic [NUM_BITS-1:0]   n,
    output logic [NUM_BITS-1:0]   result,
    output mr_pkg::mul_stat_t     stat
);

    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic [NUM_BITS-1:0] xs_reg, xs_next;
    logic [NUM_BITS-1:0] y_reg, y_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [NUM_BITS:0]   acc_sum, acc_red;
    logic [NUM_BITS:0]   dbl_sum, dbl_red;
    logic [NUM_BITS:0]   n_ext;

    assign n_ext   = {1'b0, n};
    assign acc_sum = {1'b0, acc_reg} + {1'b0, xs_reg};
    assign dbl_sum = {1'b0, xs_reg} + {1'b0, xs_reg};
    assign acc_red = (acc_sum >= n_ext) ? acc_sum - n_ext : acc_sum;
    assign dbl_red = (dbl_sum >= n_ext) ? dbl_sum - n_ext : dbl_sum;

    always_comb
    begin
        acc_next  = acc_reg;
        xs_next   = xs_reg;
        y_next    = y_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            xs_next   = x;
            y_next    = y;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_next = acc_red[NUM_BITS-1:0];
                end
                xs_next = dbl_red[NUM_BITS-1:0];
                y_next  = y_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        xs_reg  <= xs_next;
        y_reg   <= y_next;
    end

    assign result    = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### design/miller_rabin_primality_test.sv
// top level: one miller-rabin round per input beat, sticky verdict on the last witness
// depends on mr_pkg, mr_modmul and miller_rabin_primality_test_macros.svh
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------
//  in      | in_valid / in_stall   | candidate, witness, last_witness
//  out     | out_valid / out_stall | is_prime
//
// a round reduces the witness mod candidate, then per set bit of the odd part d of candidate-1
// does a multiply and a square, per clear bit a square, and up to one squaring per trailing zero
// the single bit-serial modular multiplier is reused for every product
// a candidate of two, below two or even skips the modular arithmetic and goes straight to S_FIN
// reset clears the sticky flag and out_valid; a stalled verdict holds the round end
`include "miller_rabin_primality_test_macros.svh"

module miller_rabin_primality_test #(
    parameter int NUM_BITS = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [62:0] candidate,
    input  logic [62:0] witness,
    input  logic        last_witness,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_prime
);

    localparam int KW = $clog2(NUM_BITS);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SPLIT   = 9'b000000010,
        S_RED     = 9'b000000100,
        S_POW_CHK = 9'b000001000,
        S_POW_MUL = 9'b000010000,
        S_POW_SQR = 9'b000100000,
        S_SQR_CHK = 9'b001000000,
        S_SQR     = 9'b010000000,
        S_FIN     = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [NUM_BITS-1:0] n_reg, n_next;
    logic [NUM_BITS-1:0] a_reg, a_next;
    logic [NUM_BITS-1:0] d_reg, d_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [NUM_BITS-1:0] base_reg, base_next;
    logic [NUM_BITS-1:0] r_reg, r_next;
    logic                last_reg, last_next;
    logic                composite_reg, composite_next;
    logic                out_valid_reg, out_valid_next;
    logic                is_prime_reg, is_prime_next;

    logic                mul_start;
    logic [NUM_BITS-1:0] mul_x, mul_y;
    logic [NUM_BITS-1:0] mul_result;
    mr_pkg::mul_stat_t   mul_stat;
    logic                mul_wait;

    logic [NUM_BITS-1:0] n_in;
    logic [NUM_BITS-1:0] one_c;
    logic [NUM_BITS-1:0] n_minus_one;

    assign n_in        = candidate[NUM_BITS-1:0];
    assign one_c       = NUM_BITS'(1);
    assign n_minus_one = n_reg - one_c;
    assign in_stall    = (state_reg != S_IDLE);
    assign mul_wait    = (state_reg == S_RED) || (state_reg == S_POW_MUL) ||
                         (state_reg == S_POW_SQR) || (state_reg == S_SQR);

    mr_modmul #(
        .NUM_BITS (NUM_BITS)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .n      (n_reg),
        .result (mul_result),
        .stat   (mul_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        base_next      = base_reg;
        r_next         = r_reg;
        last_next      = last_reg;
        composite_next = composite_reg;
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        mul_start      = 1'b0;
        mul_x          = '0;
        mul_y          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next    = n_in;
                    a_next    = witness[NUM_BITS-1:0];
                    last_next = last_witness;
                    d_next    = n_in - one_c;
                    k_next    = '0;
                    if (n_in == NUM_BITS'(2))
                    begin
                        state_next = S_FIN;
                    end
                    else if ((n_in < NUM_BITS'(2)) || !n_in[0])
                    begin
                        composite_next = 1'b1;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SPLIT;
                    end
                end
            end
            S_SPLIT:
            begin
                if (d_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_x      = one_c;
                    mul_y      = a_reg;
                    state_next = S_RED;
                end
                else
                begin
                    d_next = d_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
            end
            S_RED:
            begin
                if (mul_stat.done)
                begin
                    base_next  = mul_result;
                    r_next     = one_c;
                    state_next = S_POW_CHK;
                end
            end
            S_POW_CHK:
            begin
                if (d_reg == '0)
                begin
                    state_next = S_SQR_CHK;
                end
                else if (d_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_x      = r_reg;
                    mul_y      = base_reg;
                    state_next = S_POW_MUL;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_x      = base_reg;
                    mul_y      = base_reg;
                    state_next = S_POW_SQR;
                end
            end
            S_POW_MUL:
            begin
                if (mul_stat.done)
                begin
                    r_next     = mul_result;
                    mul_start  = 1'b1;
                    mul_x      = base_reg;
                    mul_y      = base_reg;
                    state_next = S_POW_SQR;
                end
            end
            S_POW_SQR:
            begin
                if (mul_stat.done)
                begin
                    base_next  = mul_result;
                    d_next     = d_reg >> 1;
                    state_next = S_POW_CHK;
                end
            end
            S_SQR_CHK:
            begin
                if (k_reg == '0)
                begin
                    if (r_reg != one_c)
                    begin
                        composite_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_x      = r_reg;
                    mul_y      = r_reg;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mul_stat.done)
                begin
                    // nontrivial square root of one
                    if ((mul_result == one_c) && (r_reg != one_c) && (r_reg != n_minus_one))
                    begin
                        composite_next = 1'b1;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        r_next     = mul_result;
                        k_next     = k_reg - KW'(1);
                        state_next = S_SQR_CHK;
                    end
                end
            end
            S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = !composite_reg;
                    composite_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            composite_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            composite_reg <= composite_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        a_reg        <= a_next;
        d_reg        <= d_next;
        k_reg        <= k_next;
        base_reg     <= base_next;
        r_reg        <= r_next;
        last_reg     <= last_next;
        is_prime_reg <= is_prime_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    `MR_ASSERT_ALWAYS(a_idle_mul_quiet, clk, (state_reg == S_IDLE) |-> !mul_stat.busy)
    `MR_ASSERT(a_done_in_wait, clk, rst_n, mul_stat.done |-> mul_wait)
    `MR_ASSERT(a_verdict_from_fin, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
    `MR_ASSERT(a_flag_cleared, clk, rst_n, $rose(out_valid_reg) |-> !composite_reg)

endmodule
